// ===== hdl/rtca_pkg.sv =====
// Package for the real-time counter with alarm: request and response types,
// operation and register codes, bit positions and reset values.
// No dependencies.
package rtca_pkg;

  localparam int unsigned PRESCALE_BITS_DEF = 20;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    REG_CRH  = 4'd0,
    REG_CRL  = 4'd1,
    REG_PRLH = 4'd2,
    REG_PRLL = 4'd3,
    REG_DIVH = 4'd4,
    REG_DIVL = 4'd5,
    REG_CNTH = 4'd6,
    REG_CNTL = 4'd7,
    REG_ALRH = 4'd8,
    REG_ALRL = 4'd9
  } reg_idx_t;

  localparam int unsigned FLAG_SEC = 0;
  localparam int unsigned FLAG_ALR = 1;
  localparam int unsigned FLAG_OW  = 2;
  localparam int unsigned FLAG_RSF = 3;
  localparam int unsigned BIT_CNF  = 4;

  localparam int unsigned IE_SEC = 0;
  localparam int unsigned IE_ALR = 1;
  localparam int unsigned IE_OW  = 2;

  localparam logic [31:0] PRESCALE_RESET = 32'h0000_8000;
  localparam logic [31:0] ALARM_RESET    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  reg_index;
    logic [15:0] write_data;
  } req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        alarm_irq;
    logic        second_irq;
    logic        overflow_irq;
  } rsp_t;

  typedef struct packed {
    logic fire;
    req_t req;
  } step_t;

endpackage

// ===== hdl/rtca_regs.sv =====
// Register file and counting logic of the real-time counter: prescaler,
// divider, 32-bit count, alarm, flags and enables, one request per step.
// Depends on rtca_pkg.
module rtca_regs import rtca_pkg::*; #(
  parameter int unsigned PRESCALE_BITS = PRESCALE_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  step_t step,
  output rsp_t  rsp
);

  localparam logic [PRESCALE_BITS-1:0] PRL_RESET = PRESCALE_BITS'(PRESCALE_RESET);

  logic [2:0]               irq_enables, irq_enables_next;
  logic                     config_mode, config_mode_next;
  logic [3:0]               status_flags, status_flags_next;
  logic [PRESCALE_BITS-1:0] prescale_reload, prescale_reload_next;
  logic [PRESCALE_BITS-1:0] divider, divider_next;
  logic [31:0]              count, count_next;
  logic [31:0]              alarm_value, alarm_value_next;

  logic [31:0] prl_wide;
  logic [31:0] div_wide;
  logic [31:0] count_inc;
  logic [15:0] rd;

  assign prl_wide  = 32'(prescale_reload);
  assign div_wide  = 32'(divider);
  assign count_inc = count + 32'd1;

  always_comb begin
    irq_enables_next     = irq_enables;
    config_mode_next     = config_mode;
    status_flags_next    = status_flags;
    prescale_reload_next = prescale_reload;
    divider_next         = divider;
    count_next           = count;
    alarm_value_next     = alarm_value;
    rd                   = '0;

    case (op_t'(step.req.op))
      OP_TICK: begin
        status_flags_next[FLAG_RSF] = 1'b1;
        if (divider == '0) begin
          divider_next                = prescale_reload;
          count_next                  = count_inc;
          status_flags_next[FLAG_SEC] = 1'b1;
          if (count_inc == '0) begin
            status_flags_next[FLAG_OW] = 1'b1;
          end
          if (count_inc == alarm_value) begin
            status_flags_next[FLAG_ALR] = 1'b1;
          end
        end else begin
          divider_next = divider - PRESCALE_BITS'(1);
        end
      end
      OP_READ: begin
        case (reg_idx_t'(step.req.reg_index))
          REG_CRH:  rd = {13'd0, irq_enables};
          REG_CRL:  rd = {10'd0, 1'b1, config_mode, status_flags};
          REG_DIVH: rd = div_wide[31:16];
          REG_DIVL: rd = div_wide[15:0];
          REG_CNTH: rd = count[31:16];
          REG_CNTL: rd = count[15:0];
          default:  rd = '0;
        endcase
      end
      OP_WRITE: begin
        case (reg_idx_t'(step.req.reg_index))
          REG_CRH: irq_enables_next = step.req.write_data[2:0];
          REG_CRL: begin
            status_flags_next = status_flags & step.req.write_data[3:0];
            config_mode_next  = step.req.write_data[BIT_CNF];
          end
          REG_PRLH: begin
            if (config_mode) begin
              prescale_reload_next =
                PRESCALE_BITS'({step.req.write_data, prl_wide[15:0]});
              divider_next = PRESCALE_BITS'({step.req.write_data, prl_wide[15:0]});
            end
          end
          REG_PRLL: begin
            if (config_mode) begin
              prescale_reload_next =
                PRESCALE_BITS'({prl_wide[31:16], step.req.write_data});
              divider_next = PRESCALE_BITS'({prl_wide[31:16], step.req.write_data});
            end
          end
          REG_CNTH: begin
            if (config_mode) begin
              count_next   = {step.req.write_data, count[15:0]};
              divider_next = prescale_reload;
            end
          end
          REG_CNTL: begin
            if (config_mode) begin
              count_next   = {count[31:16], step.req.write_data};
              divider_next = prescale_reload;
            end
          end
          REG_ALRH: begin
            if (config_mode) begin
              alarm_value_next = {step.req.write_data, alarm_value[15:0]};
            end
          end
          REG_ALRL: begin
            if (config_mode) begin
              alarm_value_next = {alarm_value[31:16], step.req.write_data};
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    rsp.read_data    = rd;
    rsp.alarm_irq    = status_flags_next[FLAG_ALR] & irq_enables_next[IE_ALR];
    rsp.second_irq   = status_flags_next[FLAG_SEC] & irq_enables_next[IE_SEC];
    rsp.overflow_irq = status_flags_next[FLAG_OW] & irq_enables_next[IE_OW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_enables     <= '0;
      config_mode     <= 1'b0;
      status_flags    <= '0;
      prescale_reload <= PRL_RESET;
      divider         <= PRL_RESET;
      count           <= '0;
      alarm_value     <= ALARM_RESET;
    end else if (step.fire) begin
      irq_enables     <= irq_enables_next;
      config_mode     <= config_mode_next;
      status_flags    <= status_flags_next;
      prescale_reload <= prescale_reload_next;
      divider         <= divider_next;
      count           <= count_next;
      alarm_value     <= alarm_value_next;
    end
  end

  a_div_within_reload: assert property (@(posedge clk) disable iff (rst)
    divider <= prescale_reload)
    else $error("divider above prescaler reload");

  a_tick_sets_sync: assert property (@(posedge clk) disable iff (rst)
    step.fire && step.req.op == OP_TICK |=> status_flags[FLAG_RSF])
    else $error("sync flag not set after tick");

  a_count_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !step.fire |=> $stable(count) && $stable(divider))
    else $error("counter moved without a request");

endmodule

// ===== hdl/rtc_counter_alarm_regs_core.sv =====
// Top level of the real-time counter with alarm: request handshake, register
// block and registered response stage.
// Depends on rtca_pkg and rtca_regs.
//
//   channel  signals                          payload
//   request  in_valid / in_ready / in_data    req_t: op, reg_index, write_data
//   response out_valid / out_ready / out_data rsp_t: read_data, three irq bits
//
// One request per cycle while responses are taken; each response appears in the cycle after its request.
// State update and response are one combinational pass into the response register.
// A request is taken while the response register is empty or being emptied.
// A stalled response holds and blocks further requests until it is taken.
// Synchronous reset restores the device reset values and empties the response.
module rtc_counter_alarm_regs_core import rtca_pkg::*; #(
  parameter int unsigned PRESCALE_BITS = PRESCALE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  step_t step;
  rsp_t  rsp;

  assign in_ready  = !out_valid || out_ready;
  assign step.fire = in_valid && in_ready;
  assign step.req  = in_data;

  rtca_regs #(
    .PRESCALE_BITS(PRESCALE_BITS)
  ) u_regs (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .rsp  (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire) begin
      out_data <= rsp;
    end
  end

  a_accept_gives_resp: assert property (@(posedge clk) disable iff (rst)
    step.fire |=> out_valid)
    else $error("accepted request produced no response");

  a_empty_takes_req: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request refused with empty response stage");

  a_reset_empties: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("response valid straight after reset");

endmodule
